// ===== rtl/complex_arithmetic_unit_assert.svh =====
// Assertion macros for the complex arithmetic unit.
// Expects clk and rst in the scope of each use.
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

// same-cycle implication
`define CAU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CAU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/cau_pkg.sv =====
// Package for the complex arithmetic unit: widths, codes, stage record,
// arctangent table and shared arithmetic helpers. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cau_pkg;

  localparam int FRAC_BITS_IN = 8;
  localparam int F2           = 2 * FRAC_BITS_IN;
  localparam int UP_SH        = 16 - FRAC_BITS_IN;
  localparam int MUL_UP       = (F2 <= 16) ? 16 - F2 : 0;
  localparam int MUL_DN       = (F2 > 16) ? F2 - 16 : 0;
  localparam int MUL_RND      = (F2 > 16) ? (1 << (F2 - 17)) : 0;

  localparam int NUM_W        = 32;
  localparam int DIV_W        = 48;
  localparam int RAD_W        = 64 - F2;
  localparam int ROOT_W       = RAD_W / 2;
  localparam int SREM_W       = ROOT_W + 2;
  localparam int CORDIC_STEPS = 24;
  localparam int CW           = 50;
  localparam int ZW           = 27;
  localparam int NSTEP        = DIV_W;

  localparam logic [31:0] HALF_PI_Q16 = 32'd102944;

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_MOD = 3'd4;
  localparam logic [2:0] OP_ARG = 3'd5;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_ERR = 2'd1;
  localparam logic [1:0] ST_SAT = 2'd2;

  typedef struct packed {
    logic [2:0]               op;
    logic                     fast;
    logic [31:0]              fast_re;
    logic [31:0]              fast_im;
    logic [1:0]               fast_status;
    logic [NUM_W-1:0]         den;
    logic                     re_neg;
    logic                     im_neg;
    logic [DIV_W-1:0]         re_nq;
    logic [DIV_W-1:0]         im_nq;
    logic [NUM_W-1:0]         re_rem;
    logic [NUM_W-1:0]         im_rem;
    logic [RAD_W-1:0]         rad;
    logic [SREM_W-1:0]        srem;
    logic [ROOT_W-1:0]        root;
    logic signed [CW-1:0]     cx;
    logic signed [CW-1:0]     cy;
    logic signed [ZW-1:0]     cz;
    logic                     cneg;
  } iter_t;

  // arctan(2^-i) in units of 2^-24 rad
  function automatic logic signed [ZW-1:0] atan_tab(input logic [4:0] idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      5'd0:  v = ZW'(13176795);
      5'd1:  v = ZW'(7778716);
      5'd2:  v = ZW'(4110060);
      5'd3:  v = ZW'(2086331);
      5'd4:  v = ZW'(1047214);
      5'd5:  v = ZW'(524117);
      5'd6:  v = ZW'(262123);
      5'd7:  v = ZW'(131069);
      5'd8:  v = ZW'(65536);
      5'd9:  v = ZW'(32768);
      5'd10: v = ZW'(16384);
      5'd11: v = ZW'(8192);
      5'd12: v = ZW'(4096);
      5'd13: v = ZW'(2048);
      5'd14: v = ZW'(1024);
      5'd15: v = ZW'(512);
      5'd16: v = ZW'(256);
      5'd17: v = ZW'(128);
      5'd18: v = ZW'(64);
      5'd19: v = ZW'(32);
      5'd20: v = ZW'(16);
      5'd21: v = ZW'(8);
      5'd22: v = ZW'(4);
      5'd23: v = ZW'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

  // {saturated, value}
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] r;
    if (v > 64'sd2147483647) r = {1'b1, 32'h7FFF_FFFF};
    else if (v < -64'sd2147483648) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, v[31:0]};
    return r;
  endfunction

  // 2*FRAC_BITS_IN fraction bits to 16, rounding half up when narrowing
  function automatic logic signed [63:0] prod_to_q16(input logic signed [63:0] p);
    logic signed [63:0] r;
    if (F2 <= 16) r = p <<< MUL_UP;
    else r = (p + 64'(MUL_RND)) >>> MUL_DN;
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/cau_front.sv =====
// Front end: operand register with six products, then the setup stage
// that forms direct results and seeds divider, root and CORDIC. Uses cau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cau_front import cau_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic               in_valid,
  input  logic [2:0]         operation,
  input  logic signed [15:0] a_real,
  input  logic signed [15:0] a_imag,
  input  logic signed [15:0] b_real,
  input  logic signed [15:0] b_imag,
  output logic               vld,
  output iter_t              stg
);

  logic               s1_vld;
  logic [2:0]         s1_op;
  logic signed [15:0] s1_ar, s1_ai, s1_br, s1_bi;
  logic signed [31:0] s1_p_rr, s1_p_ii, s1_p_ri, s1_p_ir, s1_p_aa, s1_p_bb;
  iter_t              stg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      vld    <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
      vld    <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_op   <= operation;
      s1_ar   <= a_real;
      s1_ai   <= a_imag;
      s1_br   <= b_real;
      s1_bi   <= b_imag;
      s1_p_rr <= a_real * b_real;
      s1_p_ii <= a_imag * b_imag;
      s1_p_ri <= a_real * b_imag;
      s1_p_ir <= a_imag * b_real;
      s1_p_aa <= a_real * a_real;
      s1_p_bb <= a_imag * a_imag;
      stg     <= stg_next;
    end
  end

  always_comb begin
    logic signed [63:0] add_re, add_im, sub_re, sub_im, mul_re, mul_im;
    logic signed [63:0] den64, nre, nim, nre_mag, nim_mag;
    logic [32:0]        r_add_re, r_add_im, r_sub_re, r_sub_im, r_mul_re, r_mul_im;
    logic [16:0]        ar_abs, ai_abs;

    add_re = (64'(s1_ar) + 64'(s1_br)) <<< UP_SH;
    add_im = (64'(s1_ai) + 64'(s1_bi)) <<< UP_SH;
    sub_re = (64'(s1_ar) - 64'(s1_br)) <<< UP_SH;
    sub_im = (64'(s1_ai) - 64'(s1_bi)) <<< UP_SH;
    mul_re = prod_to_q16(64'(s1_p_rr) - 64'(s1_p_ii));
    mul_im = prod_to_q16(64'(s1_p_ri) + 64'(s1_p_ir));
    r_add_re = sat32(add_re);
    r_add_im = sat32(add_im);
    r_sub_re = sat32(sub_re);
    r_sub_im = sat32(sub_im);
    r_mul_re = sat32(mul_re);
    r_mul_im = sat32(mul_im);

    den64   = 64'(s1_p_aa) + 64'(s1_p_bb);
    nre     = 64'(s1_p_rr) + 64'(s1_p_ii);
    nim     = 64'(s1_p_ri) - 64'(s1_p_ir);
    nre_mag = nre[63] ? -nre : nre;
    nim_mag = nim[63] ? -nim : nim;

    ar_abs = s1_ar[15] ? (17'd0 - 17'(s1_ar)) : 17'(s1_ar);
    ai_abs = s1_ai[15] ? (17'd0 - 17'(s1_ai)) : 17'(s1_ai);

    stg_next             = '0;
    stg_next.op          = s1_op;
    stg_next.den         = den64[NUM_W-1:0];
    stg_next.re_neg      = nre[63];
    stg_next.im_neg      = nim[63];
    stg_next.re_nq       = {nre_mag[NUM_W-1:0], {(DIV_W-NUM_W){1'b0}}};
    stg_next.im_nq       = {nim_mag[NUM_W-1:0], {(DIV_W-NUM_W){1'b0}}};
    stg_next.rad         = {den64[NUM_W-1:0], {(RAD_W-NUM_W){1'b0}}};
    stg_next.cx          = CW'({ar_abs, 32'h0});
    stg_next.cy          = CW'({ai_abs, 32'h0});
    stg_next.cneg        = s1_ar[15] ^ s1_ai[15];

    unique case (s1_op)
      OP_ADD: begin
        stg_next.fast        = 1'b1;
        stg_next.fast_re     = r_add_re[31:0];
        stg_next.fast_im     = r_add_im[31:0];
        stg_next.fast_status = (r_add_re[32] | r_add_im[32]) ? ST_SAT : ST_OK;
      end
      OP_SUB: begin
        stg_next.fast        = 1'b1;
        stg_next.fast_re     = r_sub_re[31:0];
        stg_next.fast_im     = r_sub_im[31:0];
        stg_next.fast_status = (r_sub_re[32] | r_sub_im[32]) ? ST_SAT : ST_OK;
      end
      OP_MUL: begin
        stg_next.fast        = 1'b1;
        stg_next.fast_re     = r_mul_re[31:0];
        stg_next.fast_im     = r_mul_im[31:0];
        stg_next.fast_status = (r_mul_re[32] | r_mul_im[32]) ? ST_SAT : ST_OK;
      end
      OP_DIV: begin
        stg_next.fast        = (den64[NUM_W-1:0] == '0);
        stg_next.fast_status = ST_ERR;
      end
      OP_MOD: begin
        stg_next.fast = 1'b0;
      end
      OP_ARG: begin
        stg_next.fast = (s1_ar == 16'sd0);
        if (s1_ai == 16'sd0) begin
          stg_next.fast_status = ST_ERR;
        end else begin
          stg_next.fast_status = ST_OK;
          stg_next.fast_re     = s1_ai[15] ? (32'd0 - HALF_PI_Q16) : HALF_PI_Q16;
        end
      end
      default: begin
        stg_next.fast        = 1'b1;
        stg_next.fast_status = ST_OK;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/cau_step.sv =====
// One iteration stage: a quotient bit for each divider, a root bit and a
// CORDIC rotation, as the stage index calls for. Uses cau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cau_step import cau_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  vld_in,
  input  iter_t stg_in,
  output logic  vld,
  output iter_t stg
);

  iter_t stg_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (adv) begin
      vld <= vld_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      stg <= stg_next;
    end
  end

  always_comb begin
    logic [NUM_W:0]         t_re, t_im, dext;
    logic                   ge_re, ge_im, ge_sq;
    logic [SREM_W+1:0]      r2, trial;
    logic signed [CW-1:0]   dx, dy;

    stg_next = stg_in;

    dext  = {1'b0, stg_in.den};
    t_re  = {stg_in.re_rem, stg_in.re_nq[DIV_W-1]};
    t_im  = {stg_in.im_rem, stg_in.im_nq[DIV_W-1]};
    ge_re = (t_re >= dext);
    ge_im = (t_im >= dext);
    stg_next.re_rem = ge_re ? NUM_W'(t_re - dext) : t_re[NUM_W-1:0];
    stg_next.im_rem = ge_im ? NUM_W'(t_im - dext) : t_im[NUM_W-1:0];
    stg_next.re_nq  = {stg_in.re_nq[DIV_W-2:0], ge_re};
    stg_next.im_nq  = {stg_in.im_nq[DIV_W-2:0], ge_im};

    r2    = {stg_in.srem, stg_in.rad[RAD_W-1 -: 2]};
    trial = (SREM_W+2)'({stg_in.root, 2'b01});
    ge_sq = (r2 >= trial);
    if (STEP < ROOT_W) begin
      stg_next.srem = ge_sq ? SREM_W'(r2 - trial) : r2[SREM_W-1:0];
      stg_next.root = {stg_in.root[ROOT_W-2:0], ge_sq};
      stg_next.rad  = stg_in.rad << 2;
    end

    dx = $signed(stg_in.cy) >>> STEP;
    dy = $signed(stg_in.cx) >>> STEP;
    if (STEP < CORDIC_STEPS) begin
      if (!stg_in.cy[CW-1]) begin
        stg_next.cx = stg_in.cx + dx;
        stg_next.cy = stg_in.cy - dy;
        stg_next.cz = stg_in.cz + atan_tab(5'(STEP));
      end else begin
        stg_next.cx = stg_in.cx - dx;
        stg_next.cy = stg_in.cy + dy;
        stg_next.cz = stg_in.cz - atan_tab(5'(STEP));
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cau_back.sv =====
// Back end: signs, rounds and saturates the iterated results and holds
// the output word; also drives the pipeline advance. Uses cau_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cau_back import cau_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        last_vld,
  input  iter_t       last,
  input  logic        out_stall,
  output logic        adv,
  output logic        out_valid,
  output logic [31:0] result_real,
  output logic [31:0] result_imag,
  output logic [1:0]  status
);

  logic [31:0] re_next, im_next;
  logic [1:0]  status_next;

  assign adv = !(last_vld && out_valid && out_stall);

  always_comb begin
    logic [63:0]        qre_u, qim_u;
    logic signed [63:0] qre, qim, zr, arg;
    logic [32:0]        s_re, s_im, s_root, s_arg;

    qre_u  = 64'(last.re_nq);
    qim_u  = 64'(last.im_nq);
    qre    = last.re_neg ? -$signed(qre_u) : $signed(qre_u);
    qim    = last.im_neg ? -$signed(qim_u) : $signed(qim_u);
    zr     = (64'($signed(last.cz)) + 64'sd128) >>> 8;
    arg    = last.cneg ? -zr : zr;
    s_re   = sat32(qre);
    s_im   = sat32(qim);
    s_root = sat32($signed(64'(last.root)));
    s_arg  = sat32(arg);

    re_next     = '0;
    im_next     = '0;
    status_next = ST_OK;
    if (last.fast) begin
      re_next     = last.fast_re;
      im_next     = last.fast_im;
      status_next = last.fast_status;
    end else begin
      unique case (last.op)
        OP_DIV: begin
          re_next     = s_re[31:0];
          im_next     = s_im[31:0];
          status_next = (s_re[32] | s_im[32]) ? ST_SAT : ST_OK;
        end
        OP_MOD: begin
          re_next     = s_root[31:0];
          status_next = s_root[32] ? ST_SAT : ST_OK;
        end
        OP_ARG: begin
          re_next     = s_arg[31:0];
          status_next = s_arg[32] ? ST_SAT : ST_OK;
        end
        default: begin
          status_next = ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && last_vld) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && last_vld) begin
      result_real <= re_next;
      result_imag <= im_next;
      status      <= status_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/complex_arithmetic_unit.sv =====
// Complex arithmetic unit top level: front end, iteration stages, back end.
// Depends on cau_pkg, cau_front, cau_step, cau_back and the assertion header.
//
// Usage:
//   Input channel in_valid/in_stall carries operation and operands a, b
//   (signed Q8.8). Output channel out_valid/out_stall carries result_real,
//   result_imag (signed Q16.16) and status. A word moves when valid is high
//   and stall is low at a rising edge.
//   Pipeline: a word passes through the operand/product register, the setup
//   stage, 48 iteration stages (one quotient bit each, set by the 48-bit
//   dividend of the divider) and the output register.
//   Throughput: one word per cycle for every operation while no stall holds the pipeline.
//   Stall: while the output word waits, the pipeline keeps taking words
//   until a finished result reaches its last stage; then in_stall rises and
//   everything holds until the output word is taken.
//   Reset (rst, synchronous): clears all valid bits; no word is in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "complex_arithmetic_unit_assert.svh"

module complex_arithmetic_unit import cau_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         operation,
  input  logic signed [15:0] a_real,
  input  logic signed [15:0] a_imag,
  input  logic signed [15:0] b_real,
  input  logic signed [15:0] b_imag,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_real,
  output logic signed [31:0] result_imag,
  output logic [1:0]         status
);

  logic  adv;
  logic  vld [0:NSTEP];
  iter_t stg [0:NSTEP];
  logic [31:0] re_w, im_w;

  assign in_stall    = !adv;
  assign result_real = $signed(re_w);
  assign result_imag = $signed(im_w);

  cau_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (in_valid),
    .operation (operation),
    .a_real    (a_real),
    .a_imag    (a_imag),
    .b_real    (b_real),
    .b_imag    (b_imag),
    .vld       (vld[0]),
    .stg       (stg[0])
  );

  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    cau_step #(.STEP(i)) u_step (
      .clk    (clk),
      .rst    (rst),
      .adv    (adv),
      .vld_in (vld[i]),
      .stg_in (stg[i]),
      .vld    (vld[i+1]),
      .stg    (stg[i+1])
    );
  end

  cau_back u_back (
    .clk         (clk),
    .rst         (rst),
    .last_vld    (vld[NSTEP]),
    .last        (stg[NSTEP]),
    .out_stall   (out_stall),
    .adv         (adv),
    .out_valid   (out_valid),
    .result_real (re_w),
    .result_imag (im_w),
    .status      (status)
  );

  `CAU_ASSERT_IMP(a_freeze_full, out_valid && out_stall && vld[NSTEP], in_stall, "pipeline not frozen")
  `CAU_ASSERT_NEXT(a_drain_out, vld[NSTEP] && !in_stall, out_valid, "finished word lost")
  `CAU_ASSERT_IMP(a_err_zero, out_valid && status == ST_ERR, result_real == 32'sd0 && result_imag == 32'sd0, "error word not zero")

endmodule

`default_nettype wire
